// File: hw/rtl/i2cm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  // request kinds
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRETCH_LIMIT = 1'd1;

  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_DATA_W-1:0] HALF_PERIOD_RST   = 16'd250;
  localparam logic [CFG_DATA_W-1:0] STRETCH_LIMIT_RST = 16'd1000;

  localparam int BYTE_BITS = 8;

  typedef struct packed {
    logic [1:0] req_type;
    logic       add_start;
    logic       add_stop;
    logic [7:0] tx_byte;
    logic       master_nack;
    logic       scl_in;
    logic       sda_in;
  } i2cm_in_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       target_nack;
    logic       arb_lost;
    logic       stretch_timeout;
  } i2cm_out_t;

endpackage

`default_nettype wire

// File: hw/rtl/i2c_master_byte_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Direction | Handshake             | Payload
// in       | input     | in_valid / in_stall   | in_data   (i2cm_in_t, one bus tick)
// out      | output    | out_valid / out_stall | out_data  (i2cm_out_t, one per tick)
// cfg      | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request per clock unless stalled; the bit engine state and the result
// register both update at the accepting edge, so a result appears next cycle.
// in_stall is high only while a result is held and out_stall is high.
// rst is synchronous: lines released, engine idle, registers at their defaults.
// cfg_ready is always high; writes land at the clock edge that sees cfg_valid.

module i2c_master_byte_engine_top
  import i2cm_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire i2cm_in_t         in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output i2cm_out_t             out_data,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CMP_W = (COUNT_BITS > CFG_DATA_W) ? COUNT_BITS : CFG_DATA_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [4:0] PH_IDLE    = 5'd0;
  localparam logic [4:0] PH_RS_DLY1 = 5'd1;
  localparam logic [4:0] PH_RS_STR  = 5'd2;
  localparam logic [4:0] PH_RS_DLY2 = 5'd3;
  localparam logic [4:0] PH_ST_DLY  = 5'd4;
  localparam logic [4:0] PH_WB_DLY1 = 5'd5;
  localparam logic [4:0] PH_WB_DLY2 = 5'd6;
  localparam logic [4:0] PH_WB_STR  = 5'd7;
  localparam logic [4:0] PH_RB_DLY1 = 5'd8;
  localparam logic [4:0] PH_RB_STR  = 5'd9;
  localparam logic [4:0] PH_RB_DLY2 = 5'd10;
  localparam logic [4:0] PH_SP_DLY1 = 5'd11;
  localparam logic [4:0] PH_SP_STR  = 5'd12;
  localparam logic [4:0] PH_SP_DLY2 = 5'd13;
  localparam logic [4:0] PH_SP_DLY3 = 5'd14;

  // cmd_flags bits
  localparam int FL_READ  = 0;
  localparam int FL_START = 1;
  localparam int FL_STOP  = 2;
  localparam int FL_NACK  = 3;

  logic [CFG_DATA_W-1:0] half_period_ticks;
  logic [CFG_DATA_W-1:0] stretch_limit;

  logic [4:0]            phase, phase_next;
  logic [3:0]            bit_count, bit_count_next;
  logic [7:0]            shift_reg, shift_reg_next;
  logic [COUNT_BITS-1:0] delay_count, delay_count_next;
  logic [COUNT_BITS-1:0] stretch_count, stretch_count_next;
  logic                  bus_open, bus_open_next;
  logic [3:0]            cmd_flags, cmd_flags_next;
  logic                  scl_drv, scl_drv_next;
  logic                  sda_drv, sda_drv_next;
  logic [7:0]            rx_hold, rx_hold_next;
  logic                  nack_hold, nack_hold_next;

  logic                  in_accept;
  logic                  done_p, arb_p, tmo_p;
  logic                  wb_fin, rb_fin, rb_bit, stop_now;

  logic [COUNT_BITS-1:0] delay_inc;
  logic                  delay_done;
  logic                  stretch_tmo;
  logic                  stretch0_tmo;
  logic                  out_bit;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  assign delay_inc  = (delay_count == CNT_MAX) ? delay_count : delay_count + 1'b1;
  assign delay_done = (CMP_W'(delay_inc) >= CMP_W'(half_period_ticks)) ||
                      (delay_inc == CNT_MAX);
  assign stretch_tmo = (CMP_W'(stretch_count) >= CMP_W'(stretch_limit)) ||
                       (stretch_count == CNT_MAX);
  // check right after entering the stretch phase, counter still zero
  assign stretch0_tmo = (stretch_limit == '0);
  assign out_bit = cmd_flags[FL_READ] ? cmd_flags[FL_NACK] : shift_reg[7];

  always_comb begin
    phase_next         = phase;
    bit_count_next     = bit_count;
    shift_reg_next     = shift_reg;
    delay_count_next   = delay_count;
    stretch_count_next = stretch_count;
    bus_open_next      = bus_open;
    cmd_flags_next     = cmd_flags;
    scl_drv_next       = scl_drv;
    sda_drv_next       = sda_drv;
    rx_hold_next       = rx_hold;
    nack_hold_next     = nack_hold;
    done_p   = 1'b0;
    arb_p    = 1'b0;
    tmo_p    = 1'b0;
    wb_fin   = 1'b0;
    rb_fin   = 1'b0;
    rb_bit   = 1'b0;
    stop_now = 1'b0;

    case (phase)
      PH_IDLE: begin
        if (in_data.req_type inside {REQ_WRITE, REQ_READ}) begin
          cmd_flags_next[FL_READ]  = (in_data.req_type == REQ_READ);
          cmd_flags_next[FL_START] = in_data.add_start;
          cmd_flags_next[FL_STOP]  = in_data.add_stop;
          cmd_flags_next[FL_NACK]  = in_data.master_nack;
          shift_reg_next = (in_data.req_type == REQ_WRITE) ? in_data.tx_byte : 8'd0;
          bit_count_next = 4'd0;
          if (in_data.add_start && bus_open) begin
            sda_drv_next = 1'b0;
            phase_next   = PH_RS_DLY1;
          end else if (in_data.add_start) begin
            arb_p        = ~in_data.sda_in;
            sda_drv_next = 1'b1;
            phase_next   = PH_ST_DLY;
          end else if (cmd_flags_next[FL_READ]) begin
            sda_drv_next = 1'b0;
            phase_next   = PH_RB_DLY1;
          end else begin
            sda_drv_next = ~shift_reg_next[7];
            phase_next   = PH_WB_DLY1;
          end
        end
      end
      PH_RS_DLY1: begin
        if (delay_done) begin
          scl_drv_next = 1'b0;
          phase_next   = PH_RS_STR;
        end
      end
      PH_RS_STR: begin
        if (in_data.scl_in) begin
          phase_next = PH_RS_DLY2;
        end else if (stretch_tmo) begin
          // abandoned repeated start goes straight on to the byte
          scl_drv_next = 1'b1;
          tmo_p        = 1'b1;
          sda_drv_next = cmd_flags[FL_READ] ? 1'b0 : ~shift_reg[7];
          phase_next   = cmd_flags[FL_READ] ? PH_RB_DLY1 : PH_WB_DLY1;
        end
      end
      PH_RS_DLY2: begin
        if (delay_done) begin
          arb_p        = ~in_data.sda_in;
          sda_drv_next = 1'b1;
          phase_next   = PH_ST_DLY;
        end
      end
      PH_ST_DLY: begin
        if (delay_done) begin
          scl_drv_next  = 1'b1;
          bus_open_next = 1'b1;
          sda_drv_next  = cmd_flags[FL_READ] ? 1'b0 : ~shift_reg[7];
          phase_next    = cmd_flags[FL_READ] ? PH_RB_DLY1 : PH_WB_DLY1;
        end
      end
      PH_WB_DLY1: begin
        if (delay_done) begin
          scl_drv_next = 1'b0;
          phase_next   = PH_WB_DLY2;
        end
      end
      PH_WB_DLY2: begin
        if (delay_done) begin
          if (in_data.scl_in) begin
            arb_p  = out_bit & ~in_data.sda_in;
            wb_fin = 1'b1;
          end else if (stretch0_tmo) begin
            tmo_p  = 1'b1;
            wb_fin = 1'b1;
          end else begin
            phase_next = PH_WB_STR;
          end
        end
      end
      PH_WB_STR: begin
        if (in_data.scl_in) begin
          arb_p  = out_bit & ~in_data.sda_in;
          wb_fin = 1'b1;
        end else if (stretch_tmo) begin
          tmo_p  = 1'b1;
          wb_fin = 1'b1;
        end
      end
      PH_RB_DLY1: begin
        if (delay_done) begin
          scl_drv_next = 1'b0;
          phase_next   = PH_RB_STR;
        end
      end
      PH_RB_STR: begin
        if (in_data.scl_in) begin
          phase_next = PH_RB_DLY2;
        end else if (stretch_tmo) begin
          // abandoned read bit counts as zero
          tmo_p  = 1'b1;
          rb_fin = 1'b1;
        end
      end
      PH_RB_DLY2: begin
        if (delay_done) begin
          rb_bit = in_data.sda_in;
          rb_fin = 1'b1;
        end
      end
      PH_SP_DLY1: begin
        if (delay_done) begin
          scl_drv_next = 1'b0;
          phase_next   = PH_SP_STR;
        end
      end
      PH_SP_STR: begin
        if (in_data.scl_in) begin
          phase_next = PH_SP_DLY2;
        end else if (stretch_tmo) begin
          // bus stays marked open
          scl_drv_next = 1'b1;
          tmo_p        = 1'b1;
          done_p       = 1'b1;
          phase_next   = PH_IDLE;
        end
      end
      PH_SP_DLY2: begin
        if (delay_done) begin
          sda_drv_next = 1'b0;
          phase_next   = PH_SP_DLY3;
        end
      end
      PH_SP_DLY3: begin
        if (delay_done) begin
          arb_p         = ~in_data.sda_in;
          bus_open_next = 1'b0;
          done_p        = 1'b1;
          phase_next    = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    if (wb_fin) begin
      scl_drv_next = 1'b1;
      if (cmd_flags[FL_READ]) begin
        stop_now = 1'b1;
      end else begin
        shift_reg_next = {shift_reg[6:0], 1'b0};
        bit_count_next = bit_count + 4'd1;
        if (bit_count_next < 4'(BYTE_BITS)) begin
          sda_drv_next = ~shift_reg_next[7];
          phase_next   = PH_WB_DLY1;
        end else begin
          sda_drv_next = 1'b0;
          phase_next   = PH_RB_DLY1;
        end
      end
    end

    if (rb_fin) begin
      scl_drv_next = 1'b1;
      if (!cmd_flags[FL_READ]) begin
        nack_hold_next = rb_bit;
        stop_now       = 1'b1;
      end else begin
        shift_reg_next = {shift_reg[6:0], rb_bit};
        bit_count_next = bit_count + 4'd1;
        if (bit_count_next < 4'(BYTE_BITS)) begin
          sda_drv_next = 1'b0;
          phase_next   = PH_RB_DLY1;
        end else begin
          rx_hold_next = shift_reg_next;
          sda_drv_next = ~cmd_flags[FL_NACK];
          phase_next   = PH_WB_DLY1;
        end
      end
    end

    if (stop_now) begin
      if (cmd_flags[FL_STOP]) begin
        sda_drv_next = 1'b1;
        phase_next   = PH_SP_DLY1;
      end else begin
        done_p     = 1'b1;
        phase_next = PH_IDLE;
      end
    end

    // counters restart on every phase entry
    if (phase_next != phase || wb_fin || rb_fin || done_p) begin
      delay_count_next   = '0;
      stretch_count_next = '0;
    end else begin
      case (phase)
        PH_RS_DLY1, PH_RS_DLY2, PH_ST_DLY, PH_WB_DLY1, PH_WB_DLY2,
        PH_RB_DLY1, PH_RB_DLY2, PH_SP_DLY1, PH_SP_DLY2, PH_SP_DLY3: begin
          delay_count_next = delay_inc;
        end
        PH_RS_STR, PH_WB_STR, PH_RB_STR, PH_SP_STR: begin
          stretch_count_next = stretch_count + 1'b1;
        end
        default: begin
          delay_count_next = delay_count;
        end
      endcase
    end
    // a wait that began on the entry tick has already counted once
    if (phase == PH_WB_DLY2 && phase_next == PH_WB_STR) begin
      stretch_count_next = COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RST;
      stretch_limit     <= STRETCH_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HALF_PERIOD:   half_period_ticks <= cfg_data;
        REG_STRETCH_LIMIT: stretch_limit     <= cfg_data;
        default: begin
          half_period_ticks <= half_period_ticks;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_count     <= '0;
      shift_reg     <= '0;
      delay_count   <= '0;
      stretch_count <= '0;
      bus_open      <= 1'b0;
      cmd_flags     <= '0;
      scl_drv       <= 1'b0;
      sda_drv       <= 1'b0;
      rx_hold       <= '0;
      nack_hold     <= 1'b0;
    end else if (in_accept) begin
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      shift_reg     <= shift_reg_next;
      delay_count   <= delay_count_next;
      stretch_count <= stretch_count_next;
      bus_open      <= bus_open_next;
      cmd_flags     <= cmd_flags_next;
      scl_drv       <= scl_drv_next;
      sda_drv       <= sda_drv_next;
      rx_hold       <= rx_hold_next;
      nack_hold     <= nack_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data.scl_low         <= scl_drv_next;
      out_data.sda_low         <= sda_drv_next;
      out_data.busy_res        <= (phase_next != PH_IDLE);
      out_data.done_res        <= done_p;
      out_data.rx_byte         <= rx_hold_next;
      out_data.target_nack     <= nack_hold_next;
      out_data.arb_lost        <= arb_p;
      out_data.stretch_timeout <= tmo_p;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/i2cm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cm_checker
  import i2cm_pkg::*;
(
  input wire            clk,
  input wire            rst,
  input wire            in_valid,
  input wire            in_stall,
  input wire            out_valid,
  input wire            out_stall,
  input wire i2cm_out_t out_data
);

  // input side only backs up behind a held result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // every accepted request yields a result on the next cycle
  a_request_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted request produced no result");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // finishing a command always returns to idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.done_res && out_data.busy_res))
    else $error("done and busy together");

  a_arb_tmo_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.arb_lost && out_data.stretch_timeout))
    else $error("arbitration loss and timeout on the same tick");

endmodule

bind i2c_master_byte_engine_top i2cm_checker u_i2cm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import i2cm_pkg::*;

  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_TOP = '1;
  localparam logic [1:0] REQ_RSVD = 2'd3;
  localparam longint LIMIT = 1000000;

  typedef enum logic [4:0] {
    S_IDLE, S_RS_DLY1, S_RS_STR, S_RS_DLY2, S_ST_DLY,
    S_WB_DLY1, S_WB_DLY2, S_WB_STR, S_RB_DLY1, S_RB_STR, S_RB_DLY2,
    S_SP_DLY1, S_SP_STR, S_SP_DLY2, S_SP_DLY3
  } eng_state_e;

  typedef enum logic [1:0] {CLK_WAIT, CLK_HIGH, CLK_TIMEOUT} stretch_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  i2cm_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  i2cm_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  i2c_master_byte_engine_top #(.COUNT_BITS(CNT_W)) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  i2cm_in_t  tick_q[$];
  i2cm_out_t bus_exp_q[$];
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int err_cnt = 0;
  longint cyc = 0;

  // engine mirror
  logic [CFG_DATA_W-1:0] mdl_half, mdl_stretch;
  eng_state_e mdl_state;
  logic [3:0] mdl_bits;
  logic [7:0] mdl_shift;
  logic [CNT_W-1:0] mdl_dly, mdl_str;
  logic mdl_open, mdl_rd, mdl_stop, mdl_nack;
  logic mdl_scl_low, mdl_sda_low;
  logic [7:0] mdl_rx;
  logic mdl_tnack;
  logic smp_scl, smp_sda, fl_done, fl_arb, fl_tmo;

  function automatic void goto_state(eng_state_e s);
    mdl_state = s;
    mdl_dly = '0;
    mdl_str = '0;
  endfunction

  function automatic void mirror_reset();
    mdl_half = HALF_PERIOD_RST;
    mdl_stretch = STRETCH_LIMIT_RST;
    goto_state(S_IDLE);
    mdl_bits = '0;
    mdl_shift = '0;
    mdl_open = 1'b0;
    mdl_rd = 1'b0;
    mdl_stop = 1'b0;
    mdl_nack = 1'b0;
    mdl_scl_low = 1'b0;
    mdl_sda_low = 1'b0;
    mdl_rx = '0;
    mdl_tnack = 1'b0;
  endfunction

  // a delay is at least one tick, and ends at the saturated count
  function automatic logic delay_elapsed();
    if (mdl_dly != CNT_TOP) mdl_dly = mdl_dly + 1'b1;
    return (mdl_dly >= mdl_half) || (mdl_dly == CNT_TOP);
  endfunction

  function automatic stretch_e stretch_poll();
    if (smp_scl) return CLK_HIGH;
    if (mdl_str >= mdl_stretch || mdl_str == CNT_TOP) return CLK_TIMEOUT;
    mdl_str = mdl_str + 1'b1;
    return CLK_WAIT;
  endfunction

  // read commands drive the ack bit, writes the byte MSB
  function automatic logic tx_bit();
    return mdl_rd ? mdl_nack : mdl_shift[7];
  endfunction

  function automatic void finish_cmd();
    goto_state(S_IDLE);
    fl_done = 1'b1;
  endfunction

  function automatic void close_cmd();
    if (mdl_stop) begin
      mdl_sda_low = 1'b1;
      goto_state(S_SP_DLY1);
    end else begin
      finish_cmd();
    end
  endfunction

  function automatic void begin_tx_bit();
    mdl_sda_low = ~tx_bit();
    goto_state(S_WB_DLY1);
  endfunction

  function automatic void begin_rx_bit();
    mdl_sda_low = 1'b0;
    goto_state(S_RB_DLY1);
  endfunction

  function automatic void begin_byte();
    if (mdl_rd) begin_rx_bit();
    else begin_tx_bit();
  endfunction

  function automatic void rx_bit_done(logic b);
    if (!mdl_rd) begin
      mdl_tnack = b;
      close_cmd();
    end else begin
      mdl_shift = {mdl_shift[6:0], b};
      mdl_bits++;
      if (mdl_bits < BYTE_BITS) begin
        begin_rx_bit();
      end else begin
        mdl_rx = mdl_shift;
        begin_tx_bit();
      end
    end
  endfunction

  function automatic void start_cond();
    if (!smp_sda) fl_arb = 1'b1;
    mdl_sda_low = 1'b1;
    goto_state(S_ST_DLY);
  endfunction

  function automatic void tx_stretch();
    stretch_e r;
    r = stretch_poll();
    if (r == CLK_WAIT) return;
    if (r == CLK_HIGH) begin
      if (tx_bit() && !smp_sda) fl_arb = 1'b1;
    end else begin
      fl_tmo = 1'b1;
    end
    mdl_scl_low = 1'b1;
    if (mdl_rd) begin
      close_cmd();
    end else begin
      mdl_shift = mdl_shift << 1;
      mdl_bits++;
      if (mdl_bits < BYTE_BITS) begin_tx_bit();
      else begin_rx_bit();
    end
  endfunction

  function automatic i2cm_out_t engine_tick(i2cm_in_t rq);
    i2cm_out_t o;
    stretch_e r;
    smp_scl = rq.scl_in;
    smp_sda = rq.sda_in;
    fl_done = 1'b0;
    fl_arb = 1'b0;
    fl_tmo = 1'b0;
    case (mdl_state)
      S_IDLE: if (rq.req_type == REQ_WRITE || rq.req_type == REQ_READ) begin
        mdl_rd = (rq.req_type == REQ_READ);
        mdl_stop = rq.add_stop;
        mdl_nack = rq.master_nack;
        mdl_shift = mdl_rd ? 8'h00 : rq.tx_byte;
        mdl_bits = '0;
        if (rq.add_start) begin
          if (mdl_open) begin
            mdl_sda_low = 1'b0;
            goto_state(S_RS_DLY1);
          end else begin
            start_cond();
          end
        end else begin
          begin_byte();
        end
      end
      S_RS_DLY1: if (delay_elapsed()) begin
        mdl_scl_low = 1'b0;
        goto_state(S_RS_STR);
      end
      S_RS_STR: begin
        r = stretch_poll();
        if (r == CLK_HIGH) begin
          goto_state(S_RS_DLY2);
        end else if (r == CLK_TIMEOUT) begin
          mdl_scl_low = 1'b1;
          fl_tmo = 1'b1;
          begin_byte();
        end
      end
      S_RS_DLY2: if (delay_elapsed()) start_cond();
      S_ST_DLY: if (delay_elapsed()) begin
        mdl_scl_low = 1'b1;
        mdl_open = 1'b1;
        begin_byte();
      end
      S_WB_DLY1: if (delay_elapsed()) begin
        mdl_scl_low = 1'b0;
        goto_state(S_WB_DLY2);
      end
      S_WB_DLY2: if (delay_elapsed()) begin
        goto_state(S_WB_STR);
        tx_stretch();
      end
      S_WB_STR: tx_stretch();
      S_RB_DLY1: if (delay_elapsed()) begin
        mdl_scl_low = 1'b0;
        goto_state(S_RB_STR);
      end
      S_RB_STR: begin
        r = stretch_poll();
        if (r == CLK_HIGH) begin
          goto_state(S_RB_DLY2);
        end else if (r == CLK_TIMEOUT) begin
          mdl_scl_low = 1'b1;
          fl_tmo = 1'b1;
          rx_bit_done(1'b0);
        end
      end
      S_RB_DLY2: if (delay_elapsed()) begin
        mdl_scl_low = 1'b1;
        rx_bit_done(smp_sda);
      end
      S_SP_DLY1: if (delay_elapsed()) begin
        mdl_scl_low = 1'b0;
        goto_state(S_SP_STR);
      end
      S_SP_STR: begin
        r = stretch_poll();
        if (r == CLK_HIGH) begin
          goto_state(S_SP_DLY2);
        end else if (r == CLK_TIMEOUT) begin
          // abandoned stop leaves the bus marked open
          mdl_scl_low = 1'b1;
          fl_tmo = 1'b1;
          finish_cmd();
        end
      end
      S_SP_DLY2: if (delay_elapsed()) begin
        mdl_sda_low = 1'b0;
        goto_state(S_SP_DLY3);
      end
      S_SP_DLY3: if (delay_elapsed()) begin
        if (!smp_sda) fl_arb = 1'b1;
        mdl_open = 1'b0;
        finish_cmd();
      end
      default: goto_state(S_IDLE);
    endcase
    o.scl_low = mdl_scl_low;
    o.sda_low = mdl_sda_low;
    o.busy_res = (mdl_state != S_IDLE);
    o.done_res = fl_done;
    o.rx_byte = mdl_rx;
    o.target_nack = mdl_tnack;
    o.arb_lost = fl_arb;
    o.stretch_timeout = fl_tmo;
    return o;
  endfunction

  // request source
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) bus_exp_q.push_back(engine_tick(in_data));
      if (!in_valid || !in_stall) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= tick_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (bus_exp_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("ERROR: result with nothing expected: %h", out_data);
        end else if (out_data !== bus_exp_q[0]) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("ERROR @%0t: exp scl=%b sda=%b busy=%b done=%b rx=%h tn=%b arb=%b tmo=%b",
                     $realtime, bus_exp_q[0].scl_low, bus_exp_q[0].sda_low,
                     bus_exp_q[0].busy_res, bus_exp_q[0].done_res, bus_exp_q[0].rx_byte,
                     bus_exp_q[0].target_nack, bus_exp_q[0].arb_lost,
                     bus_exp_q[0].stretch_timeout);
            $display("       got scl=%b sda=%b busy=%b done=%b rx=%h tn=%b arb=%b tmo=%b",
                     out_data.scl_low, out_data.sda_low, out_data.busy_res,
                     out_data.done_res, out_data.rx_byte, out_data.target_nack,
                     out_data.arb_lost, out_data.stretch_timeout);
          end
          void'(bus_exp_q.pop_front());
        end else begin
          void'(bus_exp_q.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT) begin
      $display("i2c_master_byte_engine_top verification failed");
      $finish;
    end
  end

  function automatic i2cm_in_t rand_item();
    i2cm_in_t it;
    logic [31:0] rnd;
    int pick;
    rnd = $urandom;
    it = rnd[$bits(i2cm_in_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 14) it.req_type = REQ_WRITE;
    else if (pick < 28) it.req_type = REQ_READ;
    else if (pick < 31) it.req_type = REQ_RSVD;
    else it.req_type = REQ_TICK;
    it.scl_in = ($urandom_range(99) < 85);
    return it;
  endfunction

  task automatic add_ticks(int n, int scl_pct, int sda_pct);
    i2cm_in_t it;
    repeat (n) begin
      it = rand_item();
      it.req_type = REQ_TICK;
      it.scl_in = ($urandom_range(99) < scl_pct);
      it.sda_in = ($urandom_range(99) < sda_pct);
      tick_q.push_back(it);
    end
  endtask

  task automatic push_cmd(logic [1:0] kind, logic st, logic sp, logic [7:0] b, logic nk);
    i2cm_in_t it;
    it.req_type = kind;
    it.add_start = st;
    it.add_stop = sp;
    it.tx_byte = b;
    it.master_nack = nk;
    it.scl_in = 1'b1;
    it.sda_in = 1'b1;
    tick_q.push_back(it);
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid || bus_exp_q.size() != 0) @(negedge clk);
  endtask

  // feed ticks until the engine has gone back to idle
  task automatic settle(int scl_pct, int sda_pct);
    forever begin
      wait_drained();
      if (mdl_state == S_IDLE) break;
      add_ticks(8, scl_pct, sda_pct);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_HALF_PERIOD) mdl_half = val;
    else mdl_stretch = val;
  endtask

  task automatic run_phase(logic [15:0] half, logic [15:0] lim, int snd, int rcv, int n);
    settle(100, 50);
    write_reg(REG_HALF_PERIOD, half);
    write_reg(REG_STRETCH_LIMIT, lim);
    @(negedge clk);
    snd_idle_pct = snd;
    rcv_stall_pct = rcv;
    repeat (n) tick_q.push_back(rand_item());
  endtask

  initial begin
    mirror_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_HALF_PERIOD, 16'd1);
    write_reg(REG_STRETCH_LIMIT, 16'd2);
    // start on a closed bus, no stop: bus stays open
    push_cmd(REQ_WRITE, 1'b1, 1'b0, 8'h00, 1'b0);
    settle(100, 100);
    // repeated start, SDA held low; the read behind it lands while busy
    push_cmd(REQ_WRITE, 1'b1, 1'b0, 8'hFF, 1'b1);
    push_cmd(REQ_READ, 1'b0, 1'b1, 8'h00, 1'b0);
    settle(100, 0);
    push_cmd(REQ_READ, 1'b1, 1'b1, 8'h00, 1'b1);
    settle(100, 50);
    push_cmd(REQ_READ, 1'b0, 1'b0, 8'hFF, 1'b0);
    settle(100, 100);
    push_cmd(REQ_RSVD, 1'b1, 1'b1, 8'hFF, 1'b1);
    add_ticks(3, 100, 50);
    settle(100, 50);
    // SCL stuck low: every stretch times out, stop included
    push_cmd(REQ_WRITE, 1'b1, 1'b1, 8'hA5, 1'b0);
    settle(0, 50);
    push_cmd(REQ_READ, 1'b1, 1'b1, 8'h00, 1'b1);
    settle(0, 50);
    write_reg(REG_HALF_PERIOD, 16'd0);
    push_cmd(REQ_WRITE, 1'b1, 1'b1, 8'h5A, 1'b1);
    settle(90, 50);

    run_phase(16'd1, 16'd0, 0, 0, 80);
    run_phase(16'd2, 16'd3, 71, 0, 80);
    run_phase(16'd0, 16'd1, 0, 71, 80);
    run_phase(16'd3, 16'hFFFF, 13, 13, 80);
    run_phase(16'd1, 16'd2, 0, 0, 80);

    // long stretch: SCL held low until a large limit runs out
    run_phase(16'd1, 16'd100, 0, 0, 0);
    push_cmd(REQ_WRITE, 1'b1, 1'b1, 8'h3C, 1'b0);
    add_ticks(120, 0, 50);
    settle(100, 50);

    // slowest bus speed; engine left idle
    run_phase(16'hFFFF, 16'hFFFF, 13, 13, 0);
    add_ticks(40, 50, 50);

    wait_drained();
    repeat (5) @(posedge clk);
    if (err_cnt == 0 && bus_exp_q.size() == 0) begin
      $display("i2c_master_byte_engine_top verification clean");
    end else begin
      $display("i2c_master_byte_engine_top verification failed");
    end
    $finish;
  end

endmodule
